// ===== src/crc32fgc_pkg.sv =====
`default_nettype none
package crc32fgc_pkg;

  localparam logic [31:0] POLY_RESET        = 32'h04C1_1DB7;
  localparam logic [31:0] INIT_RESET        = 32'h0000_0000;
  localparam logic [5:0]  HDR_SIZE_RESET    = 6'd6;
  localparam logic [7:0]  HDR_BYTE_RESET    = 8'hFF;
  localparam logic [5:0]  POS_MAX           = 6'd63;

  // register indexes on the configuration port
  localparam logic [1:0]  REG_POLYNOMIAL    = 2'd0;
  localparam logic [1:0]  REG_INIT_VALUE    = 2'd1;
  localparam logic [1:0]  REG_HEADER_SIZE   = 2'd2;
  localparam logic [1:0]  REG_HEADER_BYTE   = 2'd3;

  // function codes of an input request
  localparam logic        FUNC_GENERATE     = 1'b0;
  localparam logic        FUNC_CHECK        = 1'b1;

  // result phase within one queue entry: data byte, then crc bytes msb first
  localparam logic [2:0]  PH_DATA           = 3'd0;
  localparam logic [2:0]  PH_CRC3           = 3'd1;
  localparam logic [2:0]  PH_CRC2           = 3'd2;
  localparam logic [2:0]  PH_CRC1           = 3'd3;
  localparam logic [2:0]  PH_CRC0           = 3'd4;

  typedef struct packed {
    logic [31:0] polynomial;
    logic [31:0] init_value;
    logic [5:0]  header_size;
    logic [7:0]  header_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [31:0] rem;
    logic        good;
    logic        end0;
    logic        gen_last;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // one byte through the msb-first crc shift network
  function automatic logic [31:0] crc_byte(input logic [31:0] rem, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] r;
    r = rem ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ({r[30:0], 1'b0} ^ poly) : {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/crc32fgc_in_if.sv =====
`default_nettype none
interface crc32fgc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, func, data_byte, last_byte, input ready);
  modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== src/crc32fgc_out_if.sv =====
`default_nettype none
interface crc32fgc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] remainder;
  logic        frame_good;
  logic        frame_end;
  logic        run_last;

  modport source (output valid, out_byte, remainder, frame_good, frame_end, run_last,
                  input ready);
  modport sink   (input valid, out_byte, remainder, frame_good, frame_end, run_last,
                  output ready);
endinterface
`default_nettype wire

// ===== src/crc32fgc_cfg.sv =====
`default_nettype none
module crc32fgc_cfg
  import crc32fgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial  <= POLY_RESET;
      cfg_r.init_value  <= INIT_RESET;
      cfg_r.header_size <= HDR_SIZE_RESET;
      cfg_r.header_byte <= HDR_BYTE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_POLYNOMIAL:  cfg_r.polynomial  <= pwdata;
        REG_INIT_VALUE:  cfg_r.init_value  <= pwdata;
        REG_HEADER_SIZE: cfg_r.header_size <= pwdata[5:0];
        REG_HEADER_BYTE: cfg_r.header_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLYNOMIAL:  prdata = cfg_r.polynomial;
      REG_INIT_VALUE:  prdata = cfg_r.init_value;
      REG_HEADER_SIZE: prdata = {26'd0, cfg_r.header_size};
      REG_HEADER_BYTE: prdata = {24'd0, cfg_r.header_byte};
      default:         prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/crc32fgc_front.sv =====
`default_nettype none
module crc32fgc_front
  import crc32fgc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  crc32fgc_in_if.sink in_ch,
  input  wire fifo_stat_t stat,
  output logic        push,
  output entry_t      push_entry
);

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] cur_rem, new_rem;
  logic        in_header;

  assign in_ch.ready = ~stat.full;
  assign push        = in_ch.valid & in_ch.ready;

  always_comb begin
    cur_rem   = (pos_r == 6'd0) ? cfg.init_value : rem_r;
    in_header = pos_r < cfg.header_size;
    new_rem   = in_header ? cur_rem : crc_byte(cur_rem, in_ch.data_byte, cfg.polynomial);

    push_entry.first_byte = (in_ch.func == FUNC_GENERATE && in_header) ?
                            cfg.header_byte : in_ch.data_byte;
    push_entry.rem        = new_rem;
    push_entry.good       = (in_ch.func == FUNC_CHECK) & in_ch.last_byte & (new_rem == 32'd0);
    push_entry.end0       = (in_ch.func == FUNC_CHECK) & in_ch.last_byte;
    push_entry.gen_last   = (in_ch.func == FUNC_GENERATE) & in_ch.last_byte;

    pos_nxt = pos_r;
    rem_nxt = rem_r;
    if (push) begin
      if (in_ch.last_byte) begin
        pos_nxt = 6'd0;
        rem_nxt = cfg.init_value;
      end else begin
        rem_nxt = new_rem;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

// ===== src/crc32fgc_fifo.sv =====
`default_nettype none
module crc32fgc_fifo
  import crc32fgc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output fifo_stat_t  stat
);

  entry_t     mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head = mem[rd_ptr_r];
  assign stat = '{empty: (count_r == 2'd0), full: (count_r == 2'd2)};

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/crc32fgc_back.sv =====
`default_nettype none
module crc32fgc_back
  import crc32fgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire entry_t      head,
  input  wire fifo_stat_t  stat,
  output logic             pop,
  crc32fgc_out_if.source   out_ch
);

  logic [2:0]  phase_r, phase_nxt;
  logic        valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] rem_r;
  logic        good_r, good_nxt;
  logic        end_r, end_nxt;
  logic        last_r, last_nxt;
  logic        advance, load;

  assign advance = ~valid_r | out_ch.ready;
  assign load    = advance & ~stat.empty;

  always_comb begin
    byte_nxt  = head.rem[7:0];
    good_nxt  = 1'b0;
    end_nxt   = 1'b1;
    last_nxt  = 1'b0;
    case (phase_r)
      PH_DATA: begin
        byte_nxt = head.first_byte;
        good_nxt = head.good;
        end_nxt  = head.end0;
        last_nxt = ~head.gen_last;
      end
      PH_CRC3: byte_nxt = head.rem[31:24];
      PH_CRC2: byte_nxt = head.rem[23:16];
      PH_CRC1: byte_nxt = head.rem[15:8];
      default: last_nxt = 1'b1;
    endcase

    pop       = load & last_nxt;
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = last_nxt ? PH_DATA : phase_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (advance) begin
        valid_r <= ~stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      rem_r  <= head.rem;
      good_r <= good_nxt;
      end_r  <= end_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.remainder  = rem_r;
  assign out_ch.frame_good = good_r;
  assign out_ch.frame_end  = end_r;
  assign out_ch.run_last   = last_r;

endmodule
`default_nettype wire

// ===== src/crc32_frame_generate_check.sv =====
// path: an accepted request is written into the queue, then loaded from its head into the output register
// throughput: one byte request per cycle while the queue is not full; a generate-mode last byte
//   gives five results (one result per cycle from the back end while the output is ready)
// the two-entry queue between crc front end and result back end decouples the two sides
// reset: synchronous, active-low rst_n; clears queue, output valid, byte position and returns the
//   configuration registers to their reset values; no clearing pass, ready right after reset
`default_nettype none
module crc32_frame_generate_check
  import crc32fgc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  crc32fgc_in_if.sink      in_ch,
  crc32fgc_out_if.source   out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // register file: polynomial, init value, header size, header byte
  cfg_t       cfg;

  // front end to queue
  logic       push;
  entry_t     push_entry;

  // queue to back end
  logic       pop;
  entry_t     head;
  fifo_stat_t stat;

  crc32fgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: tracks frame position, runs the byte-wide crc network, builds one
  // queue entry per request (first output byte, remainder, status flags)
  crc32fgc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .stat       (stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue so a stalled output does not stop the crc front end at once
  crc32fgc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  // back end: expands each entry into one result, or five with the crc bytes msb first
  crc32fgc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_crc32_frame_generate_check.sv =====
`default_nettype none
module tb_crc32_frame_generate_check
  import crc32fgc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_REQUESTS = 67;
  localparam int NUM_SETTINGS   = 6;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0]  ob;
    logic [31:0] rem;
    logic        good;
    logic        fend;
    logic        rlast;
  } crc_result_t;

  // one byte request of a frame
  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       is_last;
  } byte_req_t;

  // directed row: request plus first result typed in where it is obvious
  typedef struct packed {
    logic        func;
    logic [7:0]  data;
    logic        is_last;
    logic        typed;
    logic [7:0]  t_byte;
    logic [31:0] t_rem;
    logic        t_good;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crc32fgc_in_if  in_ch ();
  crc32fgc_out_if out_ch ();

  crc32_frame_generate_check dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the registers and the running frame state
  logic [31:0] mdl_poly     = POLY_RESET;
  logic [31:0] mdl_init     = INIT_RESET;
  logic [5:0]  mdl_hdr_size = HDR_SIZE_RESET;
  logic [7:0]  mdl_hdr_byte = HDR_BYTE_RESET;
  logic [31:0] mdl_crc      = INIT_RESET;
  logic [5:0]  mdl_pos      = '0;

  crc_result_t pending_results[$];

  // typed-in values that travel with the current request
  logic        typed_req = 1'b0;
  logic [7:0]  t_byte    = '0;
  logic [31:0] t_rem     = '0;
  logic        t_good    = 1'b0;

  int tx_idle_pct = 38;
  int rx_idle_pct = 45;
  int errors = 0;
  int n_sent = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_good_frames = 0;
  int n_frames = 0;
  int n_cfg_writes = 0;
  int idle_cycles = 0;

  // directed part, run with the reset register values (header of 6 bytes, fill 0xff)
  dir_row_t dir_rows [0:21] = '{
    // generate frame: six header bytes become the fill byte, crc untouched
    '{FUNC_GENERATE, 8'h00, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'hFF, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h5A, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'hA5, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h80, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h01, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    // first payload byte: zero into a zero remainder stays zero
    '{FUNC_GENERATE, 8'h00, 1'b0, 1'b1, 8'h00, 32'h0, 1'b0},
    // last byte, four crc bytes follow
    '{FUNC_GENERATE, 8'hFF, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
    // check frame made only of header bytes: remainder stays zero, frame good
    '{FUNC_CHECK,    8'h12, 1'b0, 1'b1, 8'h12, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'hFF, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'h00, 1'b1, 1'b1, 8'h00, 32'h0, 1'b1},
    // one-byte generate frame, crc of nothing
    '{FUNC_GENERATE, 8'h3C, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
    // one-byte check frame
    '{FUNC_CHECK,    8'h80, 1'b1, 1'b1, 8'h80, 32'h0, 1'b1},
    // mode flips within one frame, header first
    '{FUNC_GENERATE, 8'hAA, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'h55, 1'b0, 1'b1, 8'h55, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h00, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'hFF, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h01, 1'b0, 1'b1, 8'hFF, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'h80, 1'b0, 1'b1, 8'h80, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'hFF, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
    '{FUNC_GENERATE, 8'h7F, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
    '{FUNC_CHECK,    8'h01, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0}
  };

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // serial form of the crc: one feedback bit per message bit, msb first
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] rem,
                                                 input logic [7:0]  b,
                                                 input logic [31:0] poly);
    logic [31:0] r;
    logic        fb;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      fb = r[31] ^ b[i];
      r  = {r[30:0], 1'b0} ^ (fb ? poly : 32'h0);
    end
    return r;
  endfunction

  // expected results of one accepted byte request, frame state advanced
  task predict_request(input logic func, input logic [7:0] data, input logic is_last);
    logic [31:0] rem;
    logic        in_hdr;
    logic [7:0]  first;
    // frame start picks up the init value, header bytes leave the crc alone
    rem    = (mdl_pos == 6'd0) ? mdl_init : mdl_crc;
    in_hdr = (mdl_pos < mdl_hdr_size);
    if (!in_hdr) rem = crc_shift_byte(rem, data, mdl_poly);
    first  = in_hdr ? mdl_hdr_byte : data;
    if (func == FUNC_CHECK) begin
      pending_results.push_back(crc_result_t'{data, rem, is_last && (rem == 32'h0),
                                              is_last, 1'b1});
    end else if (!is_last) begin
      pending_results.push_back(crc_result_t'{first, rem, 1'b0, 1'b0, 1'b1});
    end else begin
      // closing byte, then the remainder msb first
      pending_results.push_back(crc_result_t'{first, rem, 1'b0, 1'b0, 1'b0});
      pending_results.push_back(crc_result_t'{rem[31:24], rem, 1'b0, 1'b1, 1'b0});
      pending_results.push_back(crc_result_t'{rem[23:16], rem, 1'b0, 1'b1, 1'b0});
      pending_results.push_back(crc_result_t'{rem[15:8], rem, 1'b0, 1'b1, 1'b0});
      pending_results.push_back(crc_result_t'{rem[7:0], rem, 1'b0, 1'b1, 1'b1});
    end
    if (is_last) begin
      mdl_crc = mdl_init;
      mdl_pos = 6'd0;
    end else begin
      mdl_crc = rem;
      // position sticks at the top for long frames
      if (mdl_pos < POS_MAX) mdl_pos = mdl_pos + 6'd1;
    end
  endtask

  task report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // compare one accepted result with the oldest pending one
  task check_result();
    crc_result_t exp_r;
    n_results++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %02h rem %08h with nothing pending",
                                out_ch.out_byte, out_ch.remainder));
    end else begin
      exp_r = pending_results.pop_front();
      if (out_ch.out_byte !== exp_r.ob)
        report_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, exp_r.ob));
      if (out_ch.remainder !== exp_r.rem)
        report_mismatch($sformatf("remainder %08h, want %08h", out_ch.remainder, exp_r.rem));
      if (out_ch.frame_good !== exp_r.good)
        report_mismatch($sformatf("frame_good %b, want %b", out_ch.frame_good, exp_r.good));
      if (out_ch.frame_end !== exp_r.fend)
        report_mismatch($sformatf("frame_end %b, want %b", out_ch.frame_end, exp_r.fend));
      if (out_ch.run_last !== exp_r.rlast)
        report_mismatch($sformatf("run_last %b, want %b", out_ch.run_last, exp_r.rlast));
      if (exp_r.good) n_good_frames++;
    end
  endtask

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin : monitor
    crc_result_t fixed;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_request(in_ch.func, in_ch.data_byte, in_ch.last_byte);
        // typed-in rows replace the computed first result
        if (typed_req) begin
          fixed      = pending_results.pop_back();
          fixed.ob   = t_byte;
          fixed.rem  = t_rem;
          fixed.good = t_good;
          pending_results.push_back(fixed);
        end
        n_requests++;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // watchdog on cycles with no handshake and no register access
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no progress for %0d cycles, %0d results pending", idle_cycles,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // register access, entered and left at a falling edge
  task apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register takes the value at this edge
    case (idx)
      REG_POLYNOMIAL:  mdl_poly     = val;
      REG_INIT_VALUE:  mdl_init     = val;
      REG_HEADER_SIZE: mdl_hdr_size = val[5:0];
      REG_HEADER_BYTE: mdl_hdr_byte = val[7:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task verify_register(input logic [1:0] idx);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      REG_POLYNOMIAL:  want = mdl_poly;
      REG_INIT_VALUE:  want = mdl_init;
      REG_HEADER_SIZE: want = {26'd0, mdl_hdr_size};
      default:         want = {24'd0, mdl_hdr_byte};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register %0d reads %08h, want %08h", idx, got, want));
  endtask

  task set_register(input logic [1:0] idx, input logic [31:0] val);
    apb_write(idx, val);
    verify_register(idx);
  endtask

  // one byte request with random sender gaps, returns at the falling edge after acceptance
  task send_request(input logic func, input logic [7:0] data, input logic is_last,
                    input logic typed, input logic [7:0] tb, input logic [31:0] tr,
                    input logic tg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= data;
    in_ch.last_byte <= is_last;
    typed_req       <= typed;
    t_byte          <= tb;
    t_rem           <= tr;
    t_good          <= tg;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every pending result is out
  task drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // one random frame: generate, well-formed check, corrupted check, or mixed noise
  task automatic run_random_frame();
    byte_req_t   reqs[$];
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [31:0] crc;
    int          len;
    int          kind;
    int          flip;
    int          pos;
    len = $urandom_range(1, 10);
    if ($urandom_range(99) < 50) len += mdl_hdr_size;
    // a few long frames push the position into saturation
    if ($urandom_range(99) < 4) len = $urandom_range(64, 72);
    kind = $urandom_range(99);
    crc  = mdl_init;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom_range(0, 255));
      body.push_back(b);
      pos = (k < 63) ? k : 63;
      if (pos >= mdl_hdr_size) crc = crc_shift_byte(crc, b, mdl_poly);
    end
    if (kind < 40) begin
      foreach (body[k]) reqs.push_back(byte_req_t'{FUNC_GENERATE, body[k], k == len - 1});
    end else if (kind < 90) begin
      // payload followed by its own crc, msb first
      body.push_back(crc[31:24]);
      body.push_back(crc[23:16]);
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      if (kind >= 75) begin
        flip = $urandom_range(0, body.size() - 1);
        body[flip] = body[flip] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (body[k])
        reqs.push_back(byte_req_t'{FUNC_CHECK, body[k], k == body.size() - 1});
    end else begin
      foreach (body[k])
        reqs.push_back(byte_req_t'{1'($urandom_range(0, 1)), body[k], k == len - 1});
    end
    foreach (reqs[k])
      send_request(reqs[k].func, reqs[k].data, reqs[k].is_last, 1'b0, 8'h00, 32'h0, 1'b0);
    n_frames++;
  endtask

  initial begin
    logic [31:0] poly_v;
    logic [31:0] init_v;
    logic [5:0]  hdr_v;
    logic [7:0]  fill_v;
    int          phase_start;
    int          phase_frames;

    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_GENERATE;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of all four registers
    verify_register(REG_POLYNOMIAL);
    verify_register(REG_INIT_VALUE);
    verify_register(REG_HEADER_SIZE);
    verify_register(REG_HEADER_BYTE);

    // directed rows under the reset configuration
    for (int i = 0; i < $size(dir_rows); i++)
      send_request(dir_rows[i].func, dir_rows[i].data, dir_rows[i].is_last,
                   dir_rows[i].typed, dir_rows[i].t_byte, dir_rows[i].t_rem,
                   dir_rows[i].t_good);
    drain_results();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      // first receiver-heavy gaps, then sender-heavy, then none
      case (s / 2)
        0:       begin tx_idle_pct = 38; rx_idle_pct = 45; end
        1:       begin tx_idle_pct = 45; rx_idle_pct = 38; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (s)
        0: begin
          // no header, all-ones init
          poly_v = POLY_RESET;  init_v = 32'hFFFF_FFFF; hdr_v = 6'd0;  fill_v = 8'h00;
        end
        1: begin
          // widest header, all-ones polynomial
          poly_v = 32'hFFFF_FFFF; init_v = 32'h0; hdr_v = 6'd63; fill_v = 8'hFF;
        end
        2: begin
          // zero polynomial degenerates to a shift
          poly_v = 32'h0; init_v = $urandom; hdr_v = 6'd1; fill_v = 8'h5A;
        end
        3: begin
          poly_v = $urandom; init_v = $urandom;
          hdr_v  = 6'($urandom_range(0, 8)); fill_v = 8'($urandom_range(0, 255));
        end
        4: begin
          poly_v = POLY_RESET; init_v = INIT_RESET; hdr_v = HDR_SIZE_RESET; fill_v = 8'hA5;
        end
        default: begin
          poly_v = $urandom | 32'h1; init_v = $urandom;
          hdr_v  = 6'd2; fill_v = 8'($urandom_range(0, 255));
        end
      endcase
      // junk above the narrow registers must be dropped
      set_register(REG_POLYNOMIAL, poly_v);
      set_register(REG_INIT_VALUE, init_v);
      set_register(REG_HEADER_SIZE, ($urandom & 32'hFFFF_FFC0) | {26'd0, hdr_v});
      set_register(REG_HEADER_BYTE, ($urandom & 32'hFFFF_FF00) | {24'd0, fill_v});

      phase_start  = n_sent;
      phase_frames = 0;
      while (n_sent - phase_start < PHASE_REQUESTS) begin
        run_random_frame();
        phase_frames++;
        // full hold-off mid-phase so the pipeline runs dry once
        if (s == 2 && phase_frames == 3) drain_results();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d random frames, %0d good check frames",
             n_requests, n_results, n_frames, n_good_frames);
    $display("%0d register writes over %0d settings incl. header 0 and 63, zero and all-ones poly",
             n_cfg_writes, NUM_SETTINGS);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
